// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/slst_pkg.sv -----
// package of the ordered list store: request kinds and channel payload types
package slst_pkg;

	typedef enum logic [2:0] {
		KIND_CLEAR  = 3'd0,
		KIND_INSERT = 3'd1,
		KIND_DELETE = 3'd2,
		KIND_GET    = 3'd3,
		KIND_LOCATE = 3'd4,
		KIND_PRED   = 3'd5,
		KIND_SUCC   = 3'd6
	} kind_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [7:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               status;
		logic signed [31:0] data_out;
		logic [7:0]         found_position;
		logic [7:0]         list_length;
	} rsp_t;

endpackage

// ----- hdl/slst_cell.sv -----
// one list cell: holds one entry and acts on the request token passing through
module slst_cell #(
	parameter int IDX       = 0,
	parameter int WORD_BITS = 32,
	parameter int CW        = 8,
	parameter type tok_t    = logic,
	parameter type bc_t     = logic
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bc_t                  bc,
	input  tok_t                 tok_in,
	input  logic [WORD_BITS-1:0] left,
	input  logic [WORD_BITS-1:0] right,
	output logic [WORD_BITS-1:0] word,
	output tok_t                 tok_out
);

	localparam logic [CW:0] ME  = (CW+1)'(IDX);
	localparam logic [CW:0] ME1 = (CW+1)'(IDX + 1);

	logic [WORD_BITS-1:0] entry_q;
	logic [WORD_BITS-1:0] entry_d;
	tok_t                 tok_q;
	tok_t                 t;
	logic [CW:0]          cnt;
	logic [CW:0]          p;

	always_comb begin
		t       = tok_in;
		entry_d = entry_q;
		cnt     = {1'b0, bc.cnt};
		p       = {1'b0, bc.p0};
		if (tok_in.vld) begin
			case (bc.kind)
				slst_pkg::KIND_INSERT: begin
					if (bc.ok) begin
						if (ME == p) begin
							t.carry = entry_q;
							entry_d = bc.w;
						end else if (ME > p && ME <= cnt) begin
							entry_d = tok_in.carry;
							t.carry = entry_q;
						end
					end
				end
				slst_pkg::KIND_DELETE: begin
					if (bc.ok) begin
						if (ME == p) begin
							t.have = 1'b1;
							t.data = entry_q;
						end
						if (ME >= p && ME1 < cnt)
							entry_d = right;
					end
				end
				slst_pkg::KIND_GET: begin
					if (bc.ok && ME == p) begin
						t.have = 1'b1;
						t.data = entry_q;
					end
				end
				slst_pkg::KIND_LOCATE, slst_pkg::KIND_PRED, slst_pkg::KIND_SUCC: begin
					if (!tok_in.found && ME < cnt && entry_q == bc.w) begin
						t.found = 1'b1;
						t.fidx  = CW'(IDX);
						if (bc.kind == slst_pkg::KIND_PRED && IDX >= 1) begin
							t.have = 1'b1;
							t.data = left;
						end
						if (bc.kind == slst_pkg::KIND_SUCC && ME1 < cnt) begin
							t.have = 1'b1;
							t.data = right;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= t;
		end
	end

	assign word    = entry_q;
	assign tok_out = tok_q;

endmodule

// ----- hdl/sequential_list_store.sv -----
// ordered list store: top level with request control and the row of list cells
//
//  channel | signals                       | accepted when
//  req     | req_valid, req_ready, req     | req_valid && req_ready
//  rsp     | rsp_valid, rsp_ready, rsp     | rsp_valid && rsp_ready
//
// a request token walks the cell row one cell per cycle, from the start register
// through the cell registers; the next request is taken once the token has left
// the row and its response sits in the output register.
// a waiting response holds the token result until the output register frees.
// reset clears the count and control; entries hold no reset value.
module sequential_list_store #(
	parameter int DEPTH     = 128,
	parameter int WORD_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  slst_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output slst_pkg::rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = ((CW > 8) ? CW : 8) + 1;

	typedef struct packed {
		logic                 vld;
		logic                 found;
		logic                 have;
		logic [CW-1:0]        fidx;
		logic [WORD_BITS-1:0] data;
		logic [WORD_BITS-1:0] carry;
	} tok_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic                 ok;
		logic [CW-1:0]        p0;
		logic [CW-1:0]        cnt;
		logic [WORD_BITS-1:0] w;
	} bc_t;

	logic                 busy_q;
	logic                 start_q;
	logic                 fin_q;
	logic                 rsp_valid_q;
	logic [CW-1:0]        count_q;
	bc_t                  bc_q;
	tok_t                 fin_tok_q;
	slst_pkg::rsp_t       rsp_q;

	logic                 acc;
	logic                 ok_d;
	logic [PW-1:0]        pos_x;
	logic [PW-1:0]        cnt_x;
	tok_t                 tok_first;
	tok_t                 tok [DEPTH];
	logic [WORD_BITS-1:0] words [DEPTH];
	logic                 move;
	slst_pkg::rsp_t       rsp_d;
	logic [CW-1:0]        count_d;
	logic signed [63:0]   data_ext;

	assign acc       = req_valid && req_ready;
	assign req_ready = !busy_q;
	assign move      = fin_q && (!rsp_valid_q || rsp_ready);

	always_comb begin
		pos_x = PW'(req.position);
		cnt_x = PW'(count_q);
		case (req.req_type)
			slst_pkg::KIND_INSERT:
				ok_d = (pos_x != '0) && (pos_x <= cnt_x + PW'(1)) && (cnt_x < PW'(DEPTH));
			slst_pkg::KIND_DELETE, slst_pkg::KIND_GET:
				ok_d = (pos_x != '0) && (pos_x <= cnt_x);
			default:
				ok_d = 1'b0;
		endcase
	end

	always_comb begin
		tok_first     = '0;
		tok_first.vld = start_q;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] lw;
		logic [WORD_BITS-1:0] rw;
		tok_t                 tin;
		if (i == 0) begin : g_first
			assign lw  = '0;
			assign tin = tok_first;
		end else begin : g_mid
			assign lw  = words[i-1];
			assign tin = tok[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rw = '0;
		end else begin : g_inner
			assign rw = words[i+1];
		end
		slst_cell #(
			.IDX       (i),
			.WORD_BITS (WORD_BITS),
			.CW        (CW),
			.tok_t     (tok_t),
			.bc_t      (bc_t)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bc      (bc_q),
			.tok_in  (tin),
			.left    (lw),
			.right   (rw),
			.word    (words[i]),
			.tok_out (tok[i])
		);
	end

	always_comb begin
		data_ext            = 64'($signed(fin_tok_q.data));
		rsp_d               = '0;
		count_d             = count_q;
		rsp_d.data_out      = fin_tok_q.have ? 32'(data_ext) : '0;
		case (bc_q.kind)
			slst_pkg::KIND_CLEAR: begin
				rsp_d.status = 1'b0;
				count_d      = '0;
			end
			slst_pkg::KIND_INSERT: begin
				rsp_d.status = !bc_q.ok;
				if (bc_q.ok)
					count_d = count_q + CW'(1);
			end
			slst_pkg::KIND_DELETE: begin
				rsp_d.status = !bc_q.ok;
				if (bc_q.ok)
					count_d = count_q - CW'(1);
			end
			slst_pkg::KIND_GET:
				rsp_d.status = !bc_q.ok;
			slst_pkg::KIND_LOCATE: begin
				rsp_d.status = !fin_tok_q.found;
				if (fin_tok_q.found)
					rsp_d.found_position = 8'({1'b0, fin_tok_q.fidx} + (CW+1)'(1));
			end
			slst_pkg::KIND_PRED, slst_pkg::KIND_SUCC:
				rsp_d.status = !fin_tok_q.have;
			default:
				rsp_d.status = 1'b1;
		endcase
		rsp_d.list_length = 8'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			fin_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			start_q <= acc;
			if (acc)
				busy_q <= 1'b1;
			if (tok[DEPTH-1].vld)
				fin_q <= 1'b1;
			if (move) begin
				fin_q       <= 1'b0;
				busy_q      <= 1'b0;
				rsp_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			bc_q.kind <= req.req_type;
			bc_q.ok   <= ok_d;
			bc_q.p0   <= CW'(pos_x - PW'(1));
			bc_q.cnt  <= count_q;
			bc_q.w    <= WORD_BITS'(64'(req.value));
		end
		if (tok[DEPTH-1].vld)
			fin_tok_q <= tok[DEPTH-1];
		if (move)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hdl/slst_chk.sv -----
// port checker of the ordered list store and its binding to the top level
`include "assert_macros.svh"

module slst_chk #(
	parameter int DEPTH = 128
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input slst_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input slst_pkg::rsp_t rsp
);

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")
	`ASSERT_SAME(a_err_clean, clk, arst_n, rsp_valid && rsp.status, rsp.data_out == 0 && rsp.found_position == 0, "error response carries data")
	`ASSERT_SAME(a_len_bound, clk, arst_n, rsp_valid, rsp.list_length <= DEPTH, "list length above capacity")

endmodule

bind sequential_list_store slst_chk #(.DEPTH(DEPTH)) u_slst_chk (.*);

// ----- bench/tb_top.sv -----
// testbench for sequential_list_store: directed edge cases and random list operations checked against a list predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 128;
	localparam int WORD_BITS = 32;
	localparam int TOTAL_OPS = 1850;
	localparam int CALM_OPS = 150;
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct packed {
		logic [DEPTH-1:0][31:0] words;
		int unsigned len;
	} list_image_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	slst_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	slst_pkg::rsp_t rsp;

	slst_pkg::req_t pending_list_ops[$];
	slst_pkg::rsp_t expected_list_results[$];
	list_image_t plan_image = '0;
	list_image_t model_image = '0;
	slst_pkg::rsp_t model_result;
	slst_pkg::rsp_t oldest_result;
	int send_gap = 0;
	int recv_stall = 0;
	int unsigned accepted_ops = 0;
	int unsigned checked_results = 0;
	int unsigned error_results = 0;
	int unsigned peak_len = 0;
	int unsigned mismatches = 0;

	sequential_list_store #(
		.DEPTH(DEPTH),
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic apply_list_op(inout list_image_t img, input slst_pkg::req_t op,
		output slst_pkg::rsp_t res);
		int unsigned n, p, k, hit;
		logic [31:0] w;
		n = img.len;
		p = 32'(op.position);
		w = op.value;
		res = '0;
		res.status = 1'b1;
		hit = n;
		for (k = n; k > 0; k--)
			if (img.words[k-1] == w)
				hit = k - 1;
		case (op.req_type)
			slst_pkg::KIND_CLEAR: begin
				n = 0;
				res.status = 1'b0;
			end
			slst_pkg::KIND_INSERT: begin
				if (p >= 1 && p <= n + 1 && n < DEPTH) begin
					for (k = n; k >= p; k--)
						img.words[k] = img.words[k-1];
					img.words[p-1] = w;
					n++;
					res.status = 1'b0;
				end
			end
			slst_pkg::KIND_DELETE: begin
				if (p >= 1 && p <= n) begin
					res.data_out = img.words[p-1];
					for (k = p; k < n; k++)
						img.words[k-1] = img.words[k];
					n--;
					res.status = 1'b0;
				end
			end
			slst_pkg::KIND_GET: begin
				if (p >= 1 && p <= n) begin
					res.data_out = img.words[p-1];
					res.status = 1'b0;
				end
			end
			slst_pkg::KIND_LOCATE: begin
				if (hit < n) begin
					res.found_position = 8'(hit + 1);
					res.status = 1'b0;
				end
			end
			slst_pkg::KIND_PRED: begin
				if (hit < n && hit >= 1) begin
					res.data_out = img.words[hit-1];
					res.status = 1'b0;
				end
			end
			slst_pkg::KIND_SUCC: begin
				if (hit + 1 < n) begin
					res.data_out = img.words[hit+1];
					res.status = 1'b0;
				end
			end
			default: ;
		endcase
		img.len = n;
		res.list_length = 8'(n);
	endtask

	task automatic plan_op(input logic [2:0] kind, input int unsigned pos, input logic [31:0] word);
		slst_pkg::req_t op;
		slst_pkg::rsp_t unused_res;
		op.req_type = kind;
		op.position = pos[7:0];
		op.value = word;
		apply_list_op(plan_image, op, unused_res);
		pending_list_ops.push_back(op);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: rand_word = 32'h8000_0000;
			1: rand_word = 32'h7fff_ffff;
			2, 3, 4: rand_word = $urandom_range(0, 15) - 8;
			default: rand_word = $urandom();
		endcase
	endfunction

	// mostly a word already in the list so searches hit
	function automatic logic [31:0] listed_word();
		if (plan_image.len > 0 && $urandom_range(0, 3) != 0)
			listed_word = plan_image.words[$urandom_range(0, plan_image.len - 1)];
		else
			listed_word = rand_word();
	endfunction

	function automatic int unsigned pick_position(input int unsigned hi);
		if (hi > 0 && $urandom_range(0, 7) != 0)
			return $urandom_range(1, hi);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return (hi + 1 > DEPTH) ? DEPTH : hi + 1;
			2: return DEPTH;
			default: return $urandom_range(0, DEPTH);
		endcase
	endfunction

	function automatic bit idling_on();
		return pending_list_ops.size() > CALM_OPS && ((accepted_ops / 48) % 3 != 2);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v, input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(want_v), $signed(got_v));
			mismatches++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (req_valid && req_ready) begin
				apply_list_op(model_image, req, model_result);
				expected_list_results.push_back(model_result);
				accepted_ops++;
				if (model_image.len > peak_len)
					peak_len = model_image.len;
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (idling_on() && $urandom_range(0, 3) == 0) begin
					send_gap <= $urandom_range(0, 2);
					req_valid <= 1'b0;
				end else if (pending_list_ops.size() > 0) begin
					req <= pending_list_ops.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				checked_results++;
				if (rsp.status)
					error_results++;
				if (expected_list_results.size() == 0) begin
					$error("response %h with no request outstanding", rsp);
					mismatches++;
				end else begin
					oldest_result = expected_list_results.pop_front();
					check_field("status", 32'(oldest_result.status), 32'(rsp.status));
					check_field("data_out", oldest_result.data_out, rsp.data_out);
					check_field("found_position", 32'(oldest_result.found_position),
						32'(rsp.found_position));
					check_field("list_length", 32'(oldest_result.list_length),
						32'(rsp.list_length));
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				rsp_ready <= 1'b0;
			end else if (idling_on() && $urandom_range(0, 3) == 0) begin
				recv_stall <= $urandom_range(0, 2);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned mode, roll, ins_w, del_w, hi;
		logic [2:0] kind;

		// edge cases on a small list
		plan_op(slst_pkg::KIND_GET, 1, 32'd5);
		plan_op(slst_pkg::KIND_DELETE, 1, 32'd0);
		plan_op(slst_pkg::KIND_INSERT, 0, 32'd9);
		plan_op(slst_pkg::KIND_INSERT, 2, 32'd9);
		plan_op(slst_pkg::KIND_INSERT, 1, 32'h7fff_ffff);
		plan_op(slst_pkg::KIND_INSERT, 1, 32'h8000_0000);
		plan_op(slst_pkg::KIND_INSERT, 3, 32'd0);
		plan_op(slst_pkg::KIND_INSERT, 2, 32'hffff_ffff);
		plan_op(slst_pkg::KIND_GET, 4, 32'd0);
		plan_op(slst_pkg::KIND_GET, 5, 32'd0);
		plan_op(slst_pkg::KIND_LOCATE, 0, 32'h7fff_ffff);
		plan_op(slst_pkg::KIND_LOCATE, 0, 32'd5);
		plan_op(slst_pkg::KIND_PRED, 0, 32'h8000_0000);
		plan_op(slst_pkg::KIND_PRED, 0, 32'hffff_ffff);
		plan_op(slst_pkg::KIND_PRED, 0, 32'd99);
		plan_op(slst_pkg::KIND_SUCC, 0, 32'd0);
		plan_op(slst_pkg::KIND_SUCC, 0, 32'h7fff_ffff);
		plan_op(slst_pkg::KIND_SUCC, 0, 32'd12345);
		plan_op(KIND_UNUSED, 255 & 8'h80, 32'hffff_ffff);
		plan_op(slst_pkg::KIND_DELETE, 0, 32'd0);
		plan_op(slst_pkg::KIND_DELETE, 4, 32'd0);
		plan_op(slst_pkg::KIND_DELETE, 1, 32'd0);
		plan_op(slst_pkg::KIND_INSERT, DEPTH, 32'd1);
		plan_op(slst_pkg::KIND_CLEAR, 0, 32'd0);
		plan_op(slst_pkg::KIND_GET, 1, 32'd0);

		// fill to capacity, then poke the full list
		while (plan_image.len < DEPTH) begin
			hi = (plan_image.len + 1 > DEPTH) ? DEPTH : plan_image.len + 1;
			plan_op(slst_pkg::KIND_INSERT, pick_position(hi), rand_word());
		end
		plan_op(slst_pkg::KIND_INSERT, $urandom_range(1, DEPTH), rand_word());
		plan_op(slst_pkg::KIND_INSERT, DEPTH, rand_word());
		plan_op(slst_pkg::KIND_GET, DEPTH, rand_word());
		plan_op(slst_pkg::KIND_DELETE, DEPTH, rand_word());

		mode = MODE_FILL;
		while (pending_list_ops.size() < TOTAL_OPS) begin
			if (pending_list_ops.size() % 100 == 0)
				mode = $urandom_range(0, 2);
			case (mode)
				MODE_FILL: begin
					ins_w = 55;
					del_w = 10;
				end
				MODE_DRAIN: begin
					ins_w = 15;
					del_w = 45;
				end
				default: begin
					ins_w = 30;
					del_w = 25;
				end
			endcase
			roll = $urandom_range(0, 99);
			if (roll == 0)
				kind = slst_pkg::KIND_CLEAR;
			else if (roll == 1)
				kind = KIND_UNUSED;
			else if (roll < 2 + ins_w)
				kind = slst_pkg::KIND_INSERT;
			else if (roll < 2 + ins_w + del_w)
				kind = slst_pkg::KIND_DELETE;
			else begin
				case ($urandom_range(0, 3))
					0: kind = slst_pkg::KIND_GET;
					1: kind = slst_pkg::KIND_LOCATE;
					2: kind = slst_pkg::KIND_PRED;
					default: kind = slst_pkg::KIND_SUCC;
				endcase
			end
			case (kind)
				slst_pkg::KIND_INSERT: begin
					hi = (plan_image.len + 1 > DEPTH) ? DEPTH : plan_image.len + 1;
					plan_op(kind, pick_position(hi), rand_word());
				end
				slst_pkg::KIND_DELETE, slst_pkg::KIND_GET:
					plan_op(kind, pick_position(plan_image.len), rand_word());
				slst_pkg::KIND_LOCATE, slst_pkg::KIND_PRED, slst_pkg::KIND_SUCC:
					plan_op(kind, $urandom_range(0, DEPTH), listed_word());
				default:
					plan_op(kind, $urandom_range(0, DEPTH), rand_word());
			endcase
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_list_ops.size() > 0 || req_valid)
			@(posedge clk);
		while (expected_list_results.size() > 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("%0d list requests sent, %0d responses checked, %0d with error status",
			accepted_ops, checked_results, error_results);
		$display("list grew to %0d of %0d entries", peak_len, DEPTH);
		if (mismatches == 0 && expected_list_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
